### rtl/iso8583_bitmap_field_parser_defines.svh
// Assertion macros for the message parser.
`ifndef ISO8583_BITMAP_FIELD_PARSER_DEFINES_SVH
`define ISO8583_BITMAP_FIELD_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ISO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISO_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISO_ASSERT(label, prop, msg)
`define ISO_ASSERT_RST(label, prop, msg)
`endif
`endif

### rtl/iso_pkg.sv
// ----------------------------------------------------------------------------
// Message parser package
// Field formats, byte kinds, status codes and the transaction check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package iso_pkg;

  typedef enum logic [2:0] {
    FM_NONE, FM_FIXED, FM_P1BCD, FM_P2BCD, FM_P2RAW
  } fmode_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_HEAD, PH_PREFIX, PH_BODY
  } phase_t;

  localparam logic [2:0] KIND_LEN    = 3'd0;
  localparam logic [2:0] KIND_TYPE   = 3'd1;
  localparam logic [2:0] KIND_BITMAP = 3'd2;
  localparam logic [2:0] KIND_PREFIX = 3'd3;
  localparam logic [2:0] KIND_BODY   = 3'd4;
  localparam logic [2:0] KIND_IGNORE = 3'd5;

  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_LEN_ERR   = 3'd2;
  localparam logic [2:0] ST_TYPE_ERR  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [6:0] field_number;
    logic [2:0] byte_kind;
    logic       field_end;
    logic [2:0] status;
  } out_word_t;

  function automatic fmode_t field_mode(input logic [6:0] f);
    case (f)
      7'd2, 7'd35: field_mode = FM_P1BCD;
      7'd36: field_mode = FM_P2BCD;
      7'd48, 7'd54, 7'd55, 7'd60, 7'd61, 7'd62, 7'd63: field_mode = FM_P2RAW;
      7'd3, 7'd4, 7'd11, 7'd12, 7'd13, 7'd22, 7'd23, 7'd30, 7'd37, 7'd38,
      7'd39, 7'd41, 7'd49, 7'd52, 7'd64: field_mode = FM_FIXED;
      default: field_mode = FM_NONE;
    endcase
  endfunction

  function automatic logic [3:0] field_len(input logic [6:0] f);
    case (f)
      7'd3, 7'd11, 7'd12, 7'd49: field_len = 4'd3;
      7'd4, 7'd38: field_len = 4'd6;
      7'd13, 7'd22, 7'd23, 7'd39: field_len = 4'd2;
      7'd30: field_len = 4'd9;
      7'd37: field_len = 4'd12;
      7'd41, 7'd52, 7'd64: field_len = 4'd8;
      default: field_len = 4'd0;
    endcase
  endfunction

  function automatic logic type_ok(input logic [3:0] kind, input logic [23:0] pc,
                                   input logic [15:0] mt);
    case (kind)
      4'd1: type_ok = pc == 24'h920000 && mt == 16'h0810;
      4'd2: type_ok = pc == 24'h310000 && mt == 16'h0210;
      4'd3: type_ok = pc == 24'h330000 && mt == 16'h0210;
      4'd4: type_ok = (pc == 24'h600000 || pc == 24'h010000) && mt == 16'h0210;
      4'd5: type_ok = (pc == 24'h620000 || pc == 24'h210000) &&
                      (mt == 16'h0230 || mt == 16'h0210);
      4'd6: type_ok = (pc == 24'h600000 || pc == 24'h640000) && mt == 16'h0430;
      4'd7: type_ok = pc == 24'h210000 && mt == 16'h0230;
      4'd8: type_ok = pc == 24'h630000 && mt == 16'h0210;
      4'd9: type_ok = pc == 24'h620000 && mt == 16'h0210;
      4'd10: type_ok = pc == 24'h640000 && mt == 16'h0210;
      default: type_ok = 1'b1;
    endcase
  endfunction

endpackage

### rtl/iso8583_bitmap_field_parser.sv
// ----------------------------------------------------------------------------
// ISO 8583 bitmap field parser
// Classifies each message byte by header part and data element.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per cycle unless the receiver
// stalls: a message byte with first_byte and last_byte marks. The output
// channel returns one word per input word: the same byte with its field
// number, byte kind, field end mark, status and done flag. An input word is
// registered at acceptance and the parse logic writes its classification to
// the output register once that register is free. Throughput is one word per
// cycle while out_ready stays high, set by the combinational parse step and
// the bitmap priority search.
// When the receiver stalls, the output register and the input register both
// hold, and input ready falls once both are full. Reset clears the parse
// state, deal_kind and both valid flags. deal_kind is written by cfg_we with
// cfg_data and should change only while no message is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "iso8583_bitmap_field_parser_defines.svh"
module iso8583_bitmap_field_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic [6:0] field_number,
  output logic [2:0] byte_kind,
  output logic       field_end,
  output logic [2:0] status,
  output logic       done_res
);
  import iso_pkg::*;

  logic [3:0]  deal_kind;
  logic        s_valid;
  in_word_t    s_word;
  out_word_t   o_word;

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [15:0] declared_length, declared_length_next;
  logic [16:0] consumed_count, consumed_count_next;
  logic [15:0] message_type, message_type_next;
  logic [63:0] present_bits, present_bits_next;
  logic [6:0]  current_field, current_field_next;
  logic [13:0] bytes_left, bytes_left_next;
  logic [13:0] prefix_value, prefix_value_next;
  logic        prefix_stopped, prefix_stopped_next;
  logic [23:0] process_code, process_code_next;
  out_word_t   res;

  logic        s_fire, o_load;
  logic [63:0] nf_bits;
  logic [6:0]  nf_from, nf_field;
  logic        nf_found;

  assign o_load   = s_valid && (!out_valid || out_ready);
  assign s_fire   = in_valid && in_ready;
  assign in_ready = !s_valid || o_load;

  iso_next_field u_next (
    .present_bits(nf_bits),
    .from_field(nf_from),
    .found(nf_found),
    .next_field(nf_field)
  );

  always_comb begin
    logic [2:0]  st;
    logic [3:0]  hc;
    logic [3:0]  nib;
    logic [13:0] len;
    logic        fdone;
    logic        adv;
    logic [63:0] pb;
    logic [15:0] ml;
    logic [16:0] cc;
    st = ST_BUSY; fdone = 1'b0; adv = 1'b0; len = '0; nib = '0;
    phase_next = phase; header_count_next = header_count;
    declared_length_next = declared_length; consumed_count_next = consumed_count;
    message_type_next = message_type; present_bits_next = present_bits;
    current_field_next = current_field; bytes_left_next = bytes_left;
    prefix_value_next = prefix_value; prefix_stopped_next = prefix_stopped;
    process_code_next = process_code;
    res.byte_out = s_word.data_byte;
    res.field_number = '0;
    res.byte_kind = KIND_IGNORE;
    res.field_end = 1'b0;
    if (s_word.first_byte) begin
      phase_next = PH_HEAD; header_count_next = '0; declared_length_next = '0;
      consumed_count_next = '0; message_type_next = '0; present_bits_next = '0;
      current_field_next = '0; bytes_left_next = '0; prefix_value_next = '0;
      prefix_stopped_next = 1'b0; process_code_next = '0;
    end
    if (phase_next != PH_IDLE && consumed_count_next != 17'h1FFFF) begin
      consumed_count_next = consumed_count_next + 17'd1;
    end
    pb = present_bits_next;
    case (phase_next)
      PH_HEAD: begin
        hc = header_count_next;
        if (hc < 4'd2) begin
          declared_length_next = {declared_length_next[7:0], s_word.data_byte};
          res.byte_kind = KIND_LEN;
          res.field_end = (hc == 4'd1);
        end else if (hc < 4'd4) begin
          message_type_next = {message_type_next[7:0], s_word.data_byte};
          res.byte_kind = KIND_TYPE;
          res.field_end = (hc == 4'd3);
        end else begin
          present_bits_next = {present_bits_next[55:0], s_word.data_byte};
          pb = present_bits_next;
          res.byte_kind = KIND_BITMAP;
          res.field_end = (hc == 4'd11);
        end
        header_count_next = hc + 4'd1;
        if (hc >= 4'd11) begin
          adv = 1'b1;
          current_field_next = '0;
        end
      end
      PH_PREFIX: begin
        res.field_number = current_field_next;
        res.byte_kind = KIND_PREFIX;
        for (int k = 0; k < 2; k++) begin
          nib = (k == 0) ? s_word.data_byte[7:4] : s_word.data_byte[3:0];
          if (prefix_stopped_next || nib > 4'd9) begin
            prefix_stopped_next = 1'b1;
          end else begin
            prefix_value_next = 14'(prefix_value_next * 14'd10 + 14'(nib));
          end
        end
        if (bytes_left_next != '0) begin
          bytes_left_next = bytes_left_next - 14'd1;
        end
        if (bytes_left_next == '0) begin
          if (field_mode(current_field_next) == FM_P2RAW) begin
            len = prefix_value_next;
          end else begin
            len = 14'(({1'b0, prefix_value_next} + 15'd1) >> 1);
          end
          if (len == '0) begin
            res.field_end = 1'b1;
            fdone = 1'b1;
          end else begin
            phase_next = PH_BODY;
            bytes_left_next = len;
          end
        end
      end
      PH_BODY: begin
        res.field_number = current_field_next;
        res.byte_kind = KIND_BODY;
        if (current_field_next == 7'd3) begin
          process_code_next = {process_code_next[15:0], s_word.data_byte};
        end
        if (bytes_left_next != '0) begin
          bytes_left_next = bytes_left_next - 14'd1;
        end
        if (bytes_left_next == '0) begin
          res.field_end = 1'b1;
          fdone = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (fdone) begin
      if (current_field_next == 7'd3 &&
          !type_ok(deal_kind, process_code_next, message_type_next)) begin
        phase_next = PH_IDLE;
        st = ST_TYPE_ERR;
      end else begin
        adv = 1'b1;
      end
    end
    nf_bits = pb;
    nf_from = current_field_next;
    if (adv) begin
      if (nf_found) begin
        current_field_next = nf_field;
        if (field_mode(nf_field) == FM_FIXED) begin
          phase_next = PH_BODY;
          bytes_left_next = 14'(field_len(nf_field));
        end else begin
          phase_next = PH_PREFIX;
          bytes_left_next = (field_mode(nf_field) == FM_P1BCD) ? 14'd1 : 14'd2;
          prefix_value_next = '0;
          prefix_stopped_next = 1'b0;
        end
      end else begin
        phase_next = PH_IDLE;
        cc = consumed_count_next - 17'd2;
        ml = cc[15:0];
        st = (cc[16] == 1'b0 && ml == declared_length_next) ? ST_OK : ST_LEN_ERR;
      end
    end
    if (st == ST_BUSY && s_word.last_byte && phase_next != PH_IDLE) begin
      st = ST_TRUNCATED;
      phase_next = PH_IDLE;
    end
    res.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deal_kind <= '0;
      s_valid <= 1'b0;
      out_valid <= 1'b0;
      phase <= PH_IDLE;
      header_count <= '0;
      declared_length <= '0;
      consumed_count <= '0;
      message_type <= '0;
      present_bits <= '0;
      current_field <= '0;
      bytes_left <= '0;
      prefix_value <= '0;
      prefix_stopped <= 1'b0;
      process_code <= '0;
    end else begin
      if (cfg_we) begin
        deal_kind <= cfg_data;
      end
      if (s_fire) begin
        s_valid <= 1'b1;
        s_word <= '{data_byte: data_byte, first_byte: first_byte,
                    last_byte: last_byte};
      end else if (o_load) begin
        s_valid <= 1'b0;
      end
      if (o_load) begin
        out_valid <= 1'b1;
        o_word <= res;
        phase <= phase_next;
        header_count <= header_count_next;
        declared_length <= declared_length_next;
        consumed_count <= consumed_count_next;
        message_type <= message_type_next;
        present_bits <= present_bits_next;
        current_field <= current_field_next;
        bytes_left <= bytes_left_next;
        prefix_value <= prefix_value_next;
        prefix_stopped <= prefix_stopped_next;
        process_code <= process_code_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign byte_out     = o_word.byte_out;
  assign field_number = o_word.field_number;
  assign byte_kind    = o_word.byte_kind;
  assign field_end    = o_word.field_end;
  assign status       = o_word.status;
  assign done_res     = o_word.status != ST_BUSY;

  `ISO_ASSERT(a_ready_when_empty, !s_valid |-> in_ready, "ready low with empty stage")
  `ISO_ASSERT(a_out_loaded, o_load |=> out_valid, "output word lost")
  `ISO_ASSERT(a_idle_after_done, (o_load && res.status != ST_BUSY) |=> phase == PH_IDLE,
              "parser not idle after message end")
  `ISO_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !s_valid, "reset left words")
endmodule

### rtl/iso_next_field.sv
// ----------------------------------------------------------------------------
// Next field finder
// Priority search over the bitmap for the next present field with a format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iso_next_field (
  input  logic [63:0] present_bits,
  input  logic [6:0]  from_field,
  output logic        found,
  output logic [6:0]  next_field
);
  import iso_pkg::*;

  logic [64:0] cand;

  always_comb begin
    cand = '0;
    for (int f = 1; f <= 64; f++) begin
      cand[f] = present_bits[64 - f] && (field_mode(7'(f)) != FM_NONE) &&
                (7'(f) > from_field);
    end
  end

  always_comb begin
    found = 1'b0;
    next_field = '0;
    for (int f = 64; f >= 1; f--) begin
      if (cand[f]) begin
        found = 1'b1;
        next_field = 7'(f);
      end
    end
  end
endmodule

### tb/iso8583_bitmap_field_parser_test.sv
// ----------------------------------------------------------------------------
// Message parser testbench
// Sends framed messages, noise and broken messages through the byte parser,
// predicts the classification of every word and checks each output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iso8583_bitmap_field_parser_test;
  import iso_pkg::*;

  typedef struct {
    logic [7:0] byte_out;
    logic [6:0] field_number;
    logic [2:0] byte_kind;
    logic       field_end;
    logic [2:0] status;
    logic       done_res;
  } class_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       first_byte = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic [6:0] field_number;
  logic [2:0] byte_kind;
  logic       field_end;
  logic [2:0] status;
  logic       done_res;

  iso8583_bitmap_field_parser i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .first_byte(first_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .byte_out(byte_out),
    .field_number(field_number), .byte_kind(byte_kind), .field_end(field_end),
    .status(status), .done_res(done_res)
  );

  always #5 clk = ~clk;

  fmode_t      elem_mode [65];
  int          elem_size [65];
  class_word_t expected_words [$];
  int          error_count = 0;
  int          sent_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold = 0;
  int          rx_stall = 0;

  phase_t      p_phase;
  logic [3:0]  p_hdr;
  logic [15:0] p_decl;
  logic [16:0] p_used;
  logic [15:0] p_mtype;
  logic [63:0] p_bits;
  logic [6:0]  p_field;
  logic [13:0] p_left;
  logic [13:0] p_plen;
  logic        p_pstop;
  logic [23:0] p_pcode;
  logic [3:0]  p_deal;

  logic [23:0] kind_pc [11];
  logic [15:0] kind_mt [11];

  function automatic void load_tables();
    foreach (elem_mode[f]) begin
      elem_mode[f] = FM_NONE;
      elem_size[f] = 0;
    end
    elem_mode[2] = FM_P1BCD;  elem_mode[35] = FM_P1BCD;  elem_mode[36] = FM_P2BCD;
    elem_mode[48] = FM_P2RAW; elem_mode[54] = FM_P2RAW;  elem_mode[55] = FM_P2RAW;
    elem_mode[60] = FM_P2RAW; elem_mode[61] = FM_P2RAW;  elem_mode[62] = FM_P2RAW;
    elem_mode[63] = FM_P2RAW;
    elem_size[3] = 3;  elem_size[4] = 6;   elem_size[11] = 3; elem_size[12] = 3;
    elem_size[13] = 2; elem_size[22] = 2;  elem_size[23] = 2; elem_size[30] = 9;
    elem_size[37] = 12; elem_size[38] = 6; elem_size[39] = 2; elem_size[41] = 8;
    elem_size[49] = 3; elem_size[52] = 8;  elem_size[64] = 8;
    foreach (elem_size[f]) begin
      if (elem_size[f] != 0) elem_mode[f] = FM_FIXED;
    end
    kind_pc = '{24'h000000, 24'h920000, 24'h310000, 24'h330000, 24'h010000,
                24'h210000, 24'h640000, 24'h210000, 24'h630000, 24'h620000,
                24'h640000};
    kind_mt = '{16'h0000, 16'h0810, 16'h0210, 16'h0210, 16'h0210, 16'h0230,
                16'h0430, 16'h0230, 16'h0210, 16'h0210, 16'h0210};
  endfunction

  function automatic logic deal_matches();
    logic pc_ok;
    logic mt_ok;
    pc_ok = 1'b1;
    mt_ok = 1'b1;
    case (p_deal)
      4'd1: begin pc_ok = p_pcode == 24'h920000; mt_ok = p_mtype == 16'h0810; end
      4'd2: begin pc_ok = p_pcode == 24'h310000; mt_ok = p_mtype == 16'h0210; end
      4'd3: begin pc_ok = p_pcode == 24'h330000; mt_ok = p_mtype == 16'h0210; end
      4'd4: begin
        pc_ok = p_pcode == 24'h600000 || p_pcode == 24'h010000;
        mt_ok = p_mtype == 16'h0210;
      end
      4'd5: begin
        pc_ok = p_pcode == 24'h620000 || p_pcode == 24'h210000;
        mt_ok = p_mtype == 16'h0230 || p_mtype == 16'h0210;
      end
      4'd6: begin
        pc_ok = p_pcode == 24'h600000 || p_pcode == 24'h640000;
        mt_ok = p_mtype == 16'h0430;
      end
      4'd7: begin pc_ok = p_pcode == 24'h210000; mt_ok = p_mtype == 16'h0230; end
      4'd8: begin pc_ok = p_pcode == 24'h630000; mt_ok = p_mtype == 16'h0210; end
      4'd9: begin pc_ok = p_pcode == 24'h620000; mt_ok = p_mtype == 16'h0210; end
      4'd10: begin pc_ok = p_pcode == 24'h640000; mt_ok = p_mtype == 16'h0210; end
      default: ;
    endcase
    return pc_ok && mt_ok;
  endfunction

  function automatic logic [2:0] next_element(input int from);
    for (int f = from + 1; f <= 64; f++) begin
      if (p_bits[64 - f] && elem_mode[f] != FM_NONE) begin
        p_field = f[6:0];
        if (elem_mode[f] == FM_FIXED) begin
          p_phase = PH_BODY;
          p_left = elem_size[f][13:0];
        end else begin
          p_phase = PH_PREFIX;
          p_left = (elem_mode[f] == FM_P1BCD) ? 14'd1 : 14'd2;
          p_plen = '0;
          p_pstop = 1'b0;
        end
        return ST_BUSY;
      end
    end
    p_phase = PH_IDLE;
    return (32'(p_used) - 32'd2 == 32'(p_decl)) ? ST_OK : ST_LEN_ERR;
  endfunction

  function automatic logic [2:0] element_closed();
    if (p_field == 7'd3 && !deal_matches()) begin
      p_phase = PH_IDLE;
      return ST_TYPE_ERR;
    end
    return next_element(int'(p_field));
  endfunction

  function automatic void take_digit(input logic [3:0] nib);
    if (p_pstop || nib > 4'd9) p_pstop = 1'b1;
    else p_plen = 14'(p_plen * 10 + nib);
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic fb,
                                        input logic lb);
    class_word_t w;
    logic [15:0] blen;
    w.byte_out = b;
    w.field_number = '0;
    w.byte_kind = KIND_IGNORE;
    w.field_end = 1'b0;
    w.status = ST_BUSY;
    if (fb) begin
      p_phase = PH_HEAD; p_hdr = '0; p_decl = '0; p_used = '0; p_mtype = '0;
      p_bits = '0; p_field = '0; p_left = '0; p_plen = '0; p_pstop = 1'b0;
      p_pcode = '0;
    end
    if (p_phase != PH_IDLE && p_used != 17'h1FFFF) p_used++;
    case (p_phase)
      PH_HEAD: begin
        if (p_hdr < 4'd2) begin
          p_decl = {p_decl[7:0], b};
          w.byte_kind = KIND_LEN;
          w.field_end = p_hdr == 4'd1;
        end else if (p_hdr < 4'd4) begin
          p_mtype = {p_mtype[7:0], b};
          w.byte_kind = KIND_TYPE;
          w.field_end = p_hdr == 4'd3;
        end else begin
          p_bits = {p_bits[55:0], b};
          w.byte_kind = KIND_BITMAP;
          w.field_end = p_hdr == 4'd11;
        end
        p_hdr++;
        if (p_hdr == 4'd12) w.status = next_element(0);
      end
      PH_PREFIX: begin
        w.field_number = p_field;
        w.byte_kind = KIND_PREFIX;
        take_digit(b[7:4]);
        take_digit(b[3:0]);
        if (p_left != 0) p_left--;
        if (p_left == 0) begin
          blen = (elem_mode[p_field] == FM_P2RAW) ? 16'(p_plen) : (16'(p_plen) + 1) / 2;
          if (blen == 0) begin
            w.field_end = 1'b1;
            w.status = element_closed();
          end else begin
            p_phase = PH_BODY;
            p_left = blen[13:0];
          end
        end
      end
      PH_BODY: begin
        w.field_number = p_field;
        w.byte_kind = KIND_BODY;
        if (p_field == 7'd3) p_pcode = {p_pcode[15:0], b};
        if (p_left != 0) p_left--;
        if (p_left == 0) begin
          w.field_end = 1'b1;
          w.status = element_closed();
        end
      end
      default: ;
    endcase
    if (w.status == ST_BUSY && lb && p_phase != PH_IDLE) begin
      w.status = ST_TRUNCATED;
      p_phase = PH_IDLE;
    end
    w.done_res = w.status != ST_BUSY;
    expected_words.push_back(w);
  endfunction

  always @(posedge clk) begin
    class_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("Output word with none expected: byte %0h", byte_out);
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (byte_out !== w.byte_out) begin
          $error("byte_out: expected %0h, actual %0h", w.byte_out, byte_out);
          error_count++;
        end
        if (field_number !== w.field_number) begin
          $error("field_number: expected %0d, actual %0d", w.field_number, field_number);
          error_count++;
        end
        if (byte_kind !== w.byte_kind) begin
          $error("byte_kind: expected %0d, actual %0d", w.byte_kind, byte_kind);
          error_count++;
        end
        if (field_end !== w.field_end) begin
          $error("field_end: expected %0b, actual %0b", w.field_end, field_end);
          error_count++;
        end
        if (status !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, status);
          error_count++;
        end
        if (done_res !== w.done_res) begin
          $error("done_res: expected %0b, actual %0b", w.done_res, done_res);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(0, 10);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fb, input logic lb);
    int gap;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    first_byte = fb;
    last_byte = lb;
    do @(posedge clk); while (!in_ready);
    classify_byte(b, fb, lb);
    sent_count++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_deal_kind(input logic [3:0] k);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = k;
    p_deal = k;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Builds one message. Table elements appear with probability density/8,
  // elements without a table entry one time in four.
  task automatic build_message(output logic [7:0] msg [$], input int density,
                               input bit with_code, input logic [23:0] pc,
                               input logic [15:0] mt, input bit bad_len,
                               input int max_len);
    logic [63:0] bits;
    logic [7:0]  body [$];
    int          n;
    int          total;
    body = {};
    bits = '0;
    for (int f = 1; f <= 64; f++) begin
      if (elem_mode[f] == FM_NONE) bits[64 - f] = $urandom_range(0, 3) == 0;
      else bits[64 - f] = $urandom_range(0, 7) < density;
    end
    bits[61] = with_code;
    for (int f = 1; f <= 64; f++) begin
      if (bits[64 - f] && elem_mode[f] != FM_NONE) begin
        n = $urandom_range(0, max_len);
        case (elem_mode[f])
          FM_FIXED: begin
            for (int i = 0; i < elem_size[f]; i++) begin
              if (f == 3) body.push_back(pc[23 - 8 * i -: 8]);
              else body.push_back(8'($urandom));
            end
            n = -1;
          end
          FM_P1BCD: begin
            if (n < 10 && $urandom_range(0, 1)) body.push_back({4'(n), 4'hF});
            else body.push_back({4'(n / 10), 4'(n % 10)});
          end
          default: begin
            if ($urandom_range(0, 1)) begin
              body.push_back(8'h00);
              body.push_back({4'(n / 10), 4'(n % 10)});
            end else begin
              body.push_back({4'h0, 4'(n / 10)});
              body.push_back({4'(n % 10), 4'hF});
            end
          end
        endcase
        if (n >= 0) begin
          if (elem_mode[f] != FM_P2RAW) n = (n + 1) / 2;
          repeat (n) body.push_back(8'($urandom));
        end
      end
    end
    total = 12 + body.size() + (bad_len ? $urandom_range(1, 3) : 0);
    msg = {8'(total - 2 >> 8), 8'(total - 2), mt[15:8], mt[7:0]};
    for (int i = 7; i >= 0; i--) msg.push_back(bits[8 * i +: 8]);
    msg = {msg, body};
  endtask

  // cut < 0 or past the end sends the whole message; otherwise bytes stop after
  // index cut, with last_byte on the last byte sent when mark_last is set.
  task automatic send_message(input logic [7:0] msg [$], input int cut,
                              input bit mark_last);
    int stop;
    stop = (cut < 0 || cut >= msg.size()) ? msg.size() - 1 : cut;
    for (int i = 0; i <= stop; i++)
      send_byte(msg[i], i == 0, mark_last && i == stop);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), 1'b0, $urandom_range(0, 1));
  endtask

  task automatic test_header_extremes();
    logic [7:0] msg [$];
    send_noise(3);
    msg = {8'h00, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h00, 8'h00, 8'h00};
    send_message(msg, -1, 1'b1);
    msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h00, 8'h00, 8'h00};
    send_message(msg, -1, 1'b0);
    send_noise(2);
    build_message(msg, 8, 1'b1, 24'h000000, 16'h0000, 1'b0, 4);
    send_message(msg, -1, 1'b0);
    msg = {8'h00, 8'h05, 8'h02, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_message(msg, -1, 1'b0);
    msg = {8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h01, 8'h00, 8'h00, 8'h99, 8'h99, 8'hAB, 8'hCD};
    send_message(msg, -1, 1'b1);
  endtask

  // One short message per kind: a matching code, a wrong type or a wrong
  // processing code in turn. Kind 11 stands for the kinds without a check.
  task automatic test_deal_kinds();
    logic [7:0]  msg [$];
    logic [23:0] pc;
    logic [15:0] mt;
    int          j;
    for (int k = 0; k <= 11; k++) begin
      set_deal_kind(4'(k));
      j = k % 3;
      pc = (k <= 10 && j != 2) ? kind_pc[k] : 24'($urandom);
      mt = (k <= 10 && j != 1) ? kind_mt[k] : 16'($urandom);
      if (j == 0 && k == 6) pc = 24'h600000;
      build_message(msg, 0, 1'b1, pc, mt, $urandom_range(0, 3) == 0, 6);
      send_message(msg, -1, $urandom_range(0, 1));
    end
  endtask

  task automatic test_broken_messages();
    logic [7:0] msg [$];
    for (int j = 0; j < 6; j++) begin
      build_message(msg, 1, $urandom_range(0, 1), 24'($urandom), 16'($urandom),
                    1'b0, 4);
      send_message(msg, $urandom_range(0, msg.size() - 1), j % 2 == 0);
      if (j % 3 == 0) send_noise($urandom_range(1, 3));
    end
  endtask

  task automatic test_backpressure();
    logic [7:0] msg [$];
    set_deal_kind(4'd0);
    @(negedge clk);
    rx_hold = 60;
    build_message(msg, 2, 1'b1, 24'h0, 16'h0, 1'b0, 6);
    send_message(msg, -1, 1'b0);
    settle();
    build_message(msg, 1, 1'b1, 24'h0, 16'h0, 1'b0, 6);
    send_message(msg, -1, 1'b1);
  endtask

  task automatic test_random_traffic(input int target);
    logic [7:0] msg [$];
    int         pick;
    int         k;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, 10);
        set_deal_kind(4'(k));
      end
      k = int'(p_deal);
      pick = $urandom_range(0, 9);
      build_message(msg, $urandom_range(1, 5), $urandom_range(0, 3) != 0,
                    ($urandom_range(0, 2) != 0 && k <= 10) ? kind_pc[k] : 24'($urandom),
                    ($urandom_range(0, 2) != 0 && k <= 10) ? kind_mt[k] : 16'($urandom),
                    pick == 0, $urandom_range(0, 1) ? 6 : 20);
      if (pick < 7) send_message(msg, -1, $urandom_range(0, 1));
      else send_message(msg, $urandom_range(0, msg.size() - 1), pick != 9);
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 4));
    end
  endtask

  initial begin
    load_tables();
    p_phase = PH_IDLE; p_hdr = '0; p_decl = '0; p_used = '0; p_mtype = '0;
    p_bits = '0; p_field = '0; p_left = '0; p_plen = '0; p_pstop = 1'b0;
    p_pcode = '0; p_deal = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_header_extremes();
    test_deal_kinds();
    test_broken_messages();
    test_backpressure();
    test_random_traffic(sent_count + 40);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(sent_count + 40);
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
